// ----- rtl/sha1_pkg.sv -----
// sha1_pkg: shared types, constants and helpers for the sha-1 digest core
// used by sha1_ctrl, sha1_datapath and sha1_message_digest_core; no dependencies

package sha1_pkg;

    // block and digest geometry
    localparam int unsigned BlockBytes  = 64;
    localparam int unsigned PosW        = $clog2(BlockBytes);
    localparam int unsigned SchedWords  = 16;
    localparam int unsigned ChainWords  = 5;
    localparam int unsigned WordIdxW    = 3;
    localparam int unsigned RoundCount  = 80;
    localparam int unsigned RoundW      = $clog2(RoundCount);
    localparam int unsigned LenW        = 64;

    localparam logic [PosW-1:0]     PosLast    = PosW'(BlockBytes - 1);
    localparam logic [PosW-1:0]     PosLenStart = PosW'(BlockBytes - 8);
    localparam logic [RoundW-1:0]   RoundLast  = RoundW'(RoundCount - 1);
    localparam logic [WordIdxW-1:0] WordLast   = WordIdxW'(ChainWords - 1);
    localparam logic [7:0]          PadMark    = 8'h80;

    // initial chaining values
    localparam logic [31:0] InitH0 = 32'h67452301;
    localparam logic [31:0] InitH1 = 32'hEFCDAB89;
    localparam logic [31:0] InitH2 = 32'h98BADCFE;
    localparam logic [31:0] InitH3 = 32'h10325476;
    localparam logic [31:0] InitH4 = 32'hC3D2E1F0;

    // round group codes, 20 rounds each
    typedef enum logic [1:0] {
        GRP_CHOOSE = 2'd0,
        GRP_PARITY1 = 2'd1,
        GRP_MAJORITY = 2'd2,
        GRP_PARITY2 = 2'd3
    } t_round_grp;

    // source of a byte written into the block
    typedef enum logic [1:0] {
        SRC_MSG  = 2'd0,
        SRC_MARK = 2'd1,
        SRC_ZERO = 2'd2,
        SRC_LEN  = 2'd3
    } t_byte_src;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_OUTPUT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic                byte_wr;
        t_byte_src           byte_src;
        logic                count_len;
        logic                load_work;
        logic                round;
        t_round_grp          round_grp;
        logic                fold;
        logic                chain_init;
        logic [WordIdxW-1:0] word_idx;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic pos_last;
        logic pos_len_start;
    } t_dp_status;

    function automatic logic [31:0] round_const(input t_round_grp grp);
        logic [31:0] k;
        case (grp)
            GRP_CHOOSE:   k = 32'h5A827999;
            GRP_PARITY1:  k = 32'h6ED9EBA1;
            GRP_MAJORITY: k = 32'h8F1BBCDC;
            GRP_PARITY2:  k = 32'hCA62C1D6;
            default:      k = 32'h5A827999;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] round_func(input t_round_grp grp, input logic [31:0] b,
                                               input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (grp)
            GRP_CHOOSE:   f = (b & c) | (~b & d);
            GRP_MAJORITY: f = (b & c) | (b & d) | (c & d);
            GRP_PARITY1:  f = b ^ c ^ d;
            GRP_PARITY2:  f = b ^ c ^ d;
            default:      f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

// ----- rtl/sha1_datapath.sv -----
// sha1_datapath: block schedule shift line, working variables, chaining words,
// byte position and bit length counter; depends on sha1_pkg

module sha1_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_data_byte,
    input  sha1_pkg::t_dp_cmd    i_cmd,
    output sha1_pkg::t_dp_status o_status,
    output logic [31:0]          o_digest_word
);

    logic [31:0] r_w [sha1_pkg::SchedWords];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_h0, r_h1, r_h2, r_h3, r_h4;
    logic [sha1_pkg::PosW-1:0] r_pos;
    logic [sha1_pkg::LenW-1:0] r_len;

    logic [7:0]  wr_byte;
    logic [31:0] sched_xor;
    logic [31:0] sched_next;
    logic [31:0] round_sum;

    // byte selection for message and padding
    always_comb begin
        case (i_cmd.byte_src)
            sha1_pkg::SRC_MSG:  wr_byte = i_data_byte;
            sha1_pkg::SRC_MARK: wr_byte = sha1_pkg::PadMark;
            sha1_pkg::SRC_ZERO: wr_byte = 8'h00;
            sha1_pkg::SRC_LEN:  wr_byte = r_len[sha1_pkg::LenW-1 -: 8];
            default:            wr_byte = 8'h00;
        endcase
    end

    // rolling schedule word and round sum
    assign sched_xor  = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign sched_next = {sched_xor[30:0], sched_xor[31]};
    assign round_sum  = {r_a[26:0], r_a[31:27]}
                      + sha1_pkg::round_func(i_cmd.round_grp, r_b, r_c, r_d)
                      + r_e + sha1_pkg::round_const(i_cmd.round_grp) + r_w[0];

    assign o_status.pos_last      = (r_pos == sha1_pkg::PosLast);
    assign o_status.pos_len_start = (r_pos == sha1_pkg::PosLenStart);

    // schedule line: bytes shift into the newest word, rounds roll the line
    always_ff @(posedge i_clk) begin
        if (i_cmd.byte_wr) begin
            // first byte of a word pushes the finished word down the line
            if (r_pos[1:0] == 2'd0) begin
                for (int i = 0; i < sha1_pkg::SchedWords - 1; i++) begin
                    r_w[i] <= r_w[i+1];
                end
            end
            r_w[sha1_pkg::SchedWords-1] <= {r_w[sha1_pkg::SchedWords-1][23:0], wr_byte};
        end else if (i_cmd.round) begin
            for (int i = 0; i < sha1_pkg::SchedWords - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[sha1_pkg::SchedWords-1] <= sched_next;
        end
    end

    // working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_work) begin
            r_a <= r_h0;
            r_b <= r_h1;
            r_c <= r_h2;
            r_d <= r_h3;
            r_e <= r_h4;
        end else if (i_cmd.round) begin
            r_a <= round_sum;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    // chaining words, byte position and bit length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.chain_init) begin
            r_h0 <= sha1_pkg::InitH0;
            r_h1 <= sha1_pkg::InitH1;
            r_h2 <= sha1_pkg::InitH2;
            r_h3 <= sha1_pkg::InitH3;
            r_h4 <= sha1_pkg::InitH4;
        end else if (i_cmd.fold) begin
            r_h0 <= r_h0 + r_a;
            r_h1 <= r_h1 + r_b;
            r_h2 <= r_h2 + r_c;
            r_h3 <= r_h3 + r_d;
            r_h4 <= r_h4 + r_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_len <= '0;
        end else begin
            if (i_cmd.byte_wr) begin
                r_pos <= r_pos + 1'b1;
            end
            // length bytes leave from the top, leaving zero for the next message
            if (i_cmd.count_len) begin
                r_len <= r_len + sha1_pkg::LenW'(8);
            end else if (i_cmd.byte_wr && i_cmd.byte_src == sha1_pkg::SRC_LEN) begin
                r_len <= {r_len[sha1_pkg::LenW-9:0], 8'h00};
            end
        end
    end

    // digest word select
    always_comb begin
        case (i_cmd.word_idx)
            3'd0:    o_digest_word = r_h0;
            3'd1:    o_digest_word = r_h1;
            3'd2:    o_digest_word = r_h2;
            3'd3:    o_digest_word = r_h3;
            3'd4:    o_digest_word = r_h4;
            default: o_digest_word = r_h0;
        endcase
    end

endmodule

// ----- rtl/sha1_ctrl.sv -----
// sha1_ctrl: sequencer for byte intake, padding, compression rounds and digest output
// drives sha1_datapath through t_dp_cmd; depends on sha1_pkg

module sha1_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_holds_byte,
    input  logic                         i_end_of_message,
    output logic                         o_in_ready,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [sha1_pkg::WordIdxW-1:0] o_word_index,
    output logic                         o_last_word,
    input  sha1_pkg::t_dp_status         i_status,
    output sha1_pkg::t_dp_cmd            o_cmd
);

    sha1_pkg::t_state r_state, n_state;
    sha1_pkg::t_state r_ret, n_ret;
    logic [sha1_pkg::RoundW-1:0]   r_round, n_round;
    logic [sha1_pkg::WordIdxW-1:0] r_word, n_word;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha1_pkg::ST_IDLE;
            r_ret   <= sha1_pkg::ST_IDLE;
            r_round <= '0;
            r_word  <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_round <= n_round;
            r_word  <= n_word;
        end
    end

    assign o_word_index = r_word;
    assign o_last_word  = (r_word == sha1_pkg::WordLast);

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_round     = r_round;
        n_word      = r_word;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd           = '0;
        o_cmd.word_idx  = r_word;
        if (r_round < sha1_pkg::RoundW'(20)) begin
            o_cmd.round_grp = sha1_pkg::GRP_CHOOSE;
        end else if (r_round < sha1_pkg::RoundW'(40)) begin
            o_cmd.round_grp = sha1_pkg::GRP_PARITY1;
        end else if (r_round < sha1_pkg::RoundW'(60)) begin
            o_cmd.round_grp = sha1_pkg::GRP_MAJORITY;
        end else begin
            o_cmd.round_grp = sha1_pkg::GRP_PARITY2;
        end

        case (r_state)
            sha1_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_holds_byte) begin
                        o_cmd.byte_wr   = 1'b1;
                        o_cmd.byte_src  = sha1_pkg::SRC_MSG;
                        o_cmd.count_len = 1'b1;
                    end
                    if (i_holds_byte && i_status.pos_last) begin
                        n_state = sha1_pkg::ST_LOAD;
                        n_ret   = i_end_of_message ? sha1_pkg::ST_PAD_MARK
                                                   : sha1_pkg::ST_IDLE;
                    end else if (i_end_of_message) begin
                        n_state = sha1_pkg::ST_PAD_MARK;
                    end
                end
            end
            sha1_pkg::ST_LOAD: begin
                o_cmd.load_work = 1'b1;
                n_round = '0;
                n_state = sha1_pkg::ST_ROUND;
            end
            sha1_pkg::ST_ROUND: begin
                o_cmd.round = 1'b1;
                if (r_round == sha1_pkg::RoundLast) begin
                    n_state = sha1_pkg::ST_FOLD;
                end else begin
                    n_round = r_round + 1'b1;
                end
            end
            sha1_pkg::ST_FOLD: begin
                o_cmd.fold = 1'b1;
                n_state = r_ret;
            end
            sha1_pkg::ST_PAD_MARK: begin
                o_cmd.byte_wr  = 1'b1;
                o_cmd.byte_src = sha1_pkg::SRC_MARK;
                if (i_status.pos_last) begin
                    n_state = sha1_pkg::ST_LOAD;
                    n_ret   = sha1_pkg::ST_PAD_ZERO;
                end else begin
                    n_state = sha1_pkg::ST_PAD_ZERO;
                end
            end
            sha1_pkg::ST_PAD_ZERO: begin
                // zeros up to the length field, through an extra block if needed
                if (i_status.pos_len_start) begin
                    n_state = sha1_pkg::ST_PAD_LEN;
                end else begin
                    o_cmd.byte_wr  = 1'b1;
                    o_cmd.byte_src = sha1_pkg::SRC_ZERO;
                    if (i_status.pos_last) begin
                        n_state = sha1_pkg::ST_LOAD;
                        n_ret   = sha1_pkg::ST_PAD_ZERO;
                    end
                end
            end
            sha1_pkg::ST_PAD_LEN: begin
                o_cmd.byte_wr  = 1'b1;
                o_cmd.byte_src = sha1_pkg::SRC_LEN;
                if (i_status.pos_last) begin
                    n_state = sha1_pkg::ST_LOAD;
                    n_ret   = sha1_pkg::ST_OUTPUT;
                end
            end
            sha1_pkg::ST_OUTPUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (r_word == sha1_pkg::WordLast) begin
                        o_cmd.chain_init = 1'b1;
                        n_word  = '0;
                        n_state = sha1_pkg::ST_IDLE;
                    end else begin
                        n_word = r_word + 1'b1;
                    end
                end
            end
            default: begin
                n_state = sha1_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/sha1_message_digest_core.sv -----
// sha1_message_digest_core: top level of the sha-1 digest engine
// instantiates sha1_ctrl and sha1_datapath; depends on sha1_pkg
//
// channel   direction  tdata                 tuser                tlast
// s_axis    in         [7:0] data_byte       [0] holds_byte       end_of_message
// m_axis    out        [31:0] digest_word    [2:0] word_index     last_word
//
// message bytes are taken while the sequencer is idle; every 64th byte starts a compression
// (load, 80 rounds on one shared round unit, fold), during which no request is taken.
// an end request pads one byte per cycle, pausing for each compression and once at the
// length field, runs one or two compressions, then offers five words.
// the input is stalled from end of message until the fifth word is taken.
// reset (i_rst_n low, synchronous) loads the initial chaining values and clears counts.

module sha1_message_digest_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [7:0]                   i_s_axis_tdata,  // [7:0] data_byte
    input  logic                         i_s_axis_tuser,  // [0] holds_byte
    input  logic                         i_s_axis_tlast,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [31:0]                  o_m_axis_tdata,  // [31:0] digest_word
    output logic [sha1_pkg::WordIdxW-1:0] o_m_axis_tuser, // [2:0] word_index
    output logic                         o_m_axis_tlast
);

    sha1_pkg::t_dp_cmd    dp_cmd;
    sha1_pkg::t_dp_status dp_status;

    // sequencer
    sha1_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_s_axis_tvalid),
        .i_holds_byte     (i_s_axis_tuser),
        .i_end_of_message (i_s_axis_tlast),
        .o_in_ready       (o_s_axis_tready),
        .o_out_valid      (o_m_axis_tvalid),
        .i_out_ready      (i_m_axis_tready),
        .o_word_index     (o_m_axis_tuser),
        .o_last_word      (o_m_axis_tlast),
        .i_status         (dp_status),
        .o_cmd            (dp_cmd)
    );

    // hash datapath
    sha1_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (i_s_axis_tdata),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .o_digest_word (o_m_axis_tdata)
    );

endmodule

// ----- test/tb.sv -----
// tb: self-checking bench for sha1_message_digest_core, driven over its byte and digest streams
// holds a sha-1 digest model with a scoreboard class; depends on sha1_pkg and the core rtl

`timescale 1ns / 1ps

// one digest word as it leaves the core
typedef struct packed {
    logic [31:0]                   word;
    logic [sha1_pkg::WordIdxW-1:0] idx;
    logic                          last;
} t_digest_word;

// sha-1 digest model and scoreboard of expected digest words
class sha1_digest_model;

    logic [31:0]  chain [5];
    logic [7:0]   blk [64];
    logic [5:0]   fill_pos;
    logic [63:0]  msg_bits;
    t_digest_word pending_words [$];
    int unsigned  mismatch_count;

    function new();
        load_initial();
        foreach (blk[i]) blk[i] = 8'h00;
        fill_pos       = '0;
        msg_bits       = '0;
        mismatch_count = 0;
    endfunction

    function void load_initial();
        chain[0] = 32'h67452301;
        chain[1] = 32'hEFCDAB89;
        chain[2] = 32'h98BADCFE;
        chain[3] = 32'h10325476;
        chain[4] = 32'hC3D2E1F0;
    endfunction

    function logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // 80 rounds over the block with a 16-word rolling schedule
    function void compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        int s;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int r = 0; r < 80; r++) begin
            s = r % 16;
            if (r >= 16)
                w[s] = rotl(w[(s+13)%16] ^ w[(s+8)%16] ^ w[(s+2)%16] ^ w[s], 1);
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = rotl(a, 5) + f + e + k + w[s];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endfunction

    // note one accepted request, queue the digest when it ends a message
    function void take_request(input logic [7:0] data, input logic holds, input logic ends);
        t_digest_word exp;
        if (holds) begin
            blk[fill_pos] = data;
            fill_pos++;
            msg_bits += 64'd8;
            if (fill_pos == 6'd0)
                compress_block();
        end
        if (!ends)
            return;
        // padding: marker, zeros, then big-endian bit count
        blk[fill_pos] = 8'h80;
        for (int i = int'(fill_pos) + 1; i < 64; i++)
            blk[i] = 8'h00;
        if (int'(fill_pos) + 1 > 56) begin
            compress_block();
            foreach (blk[i]) blk[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++)
            blk[63-i] = msg_bits[8*i +: 8];
        compress_block();
        for (int i = 0; i < 5; i++) begin
            exp.word = chain[i];
            exp.idx  = sha1_pkg::WordIdxW'(i);
            exp.last = (i == 4);
            pending_words.push_back(exp);
        end
        // fresh message
        load_initial();
        fill_pos = '0;
        msg_bits = '0;
    endfunction

    function void flag(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    // compare one accepted digest word with the oldest expectation
    function void check_digest_word(input logic [31:0] word,
                                    input logic [sha1_pkg::WordIdxW-1:0] idx,
                                    input logic last);
        t_digest_word want;
        if (pending_words.size() == 0) begin
            flag($sformatf("unexpected word %h index %0d last %b", word, idx, last));
            return;
        end
        want = pending_words.pop_front();
        if (word !== want.word || idx !== want.idx || last !== want.last)
            flag($sformatf("expected word %h index %0d last %b, got %h index %0d last %b",
                           want.word, want.idx, want.last, word, idx, last));
    endfunction

endclass

module tb;

    logic                          i_clk;
    logic                          i_rst_n  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic [7:0]                    s_tdata  = 8'h00;  // [7:0] data_byte
    logic                          s_tuser  = 1'b0;   // [0] holds_byte
    logic                          s_tlast  = 1'b0;   // end_of_message
    logic                          s_tready;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [31:0]                   m_tdata;           // [31:0] digest_word
    logic [sha1_pkg::WordIdxW-1:0] m_tuser;           // [2:0] word_index
    logic                          m_tlast;           // last_word

    sha1_digest_model digest_model;
    int unsigned      request_count = 0;
    int unsigned      stall_left    = 0;
    bit               no_idle       = 1'b0;
    bit               hold_off_req  = 1'b0;
    int unsigned      boundary_len [4] = '{55, 56, 63, 64};

    sha1_message_digest_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one request and hold it until taken
    task automatic send_request(input logic [7:0] data, input logic holds, input logic ends);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= holds;
        s_tlast  <= ends;
        do @(posedge i_clk); while (!s_tready);
        digest_model.take_request(data, holds, ends);
        if (holds || ends)
            request_count++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // one message of random bytes with stray empty requests mixed in
    task automatic send_message(input int unsigned len);
        bit fused;
        fused = $urandom_range(0, 1);
        for (int unsigned n = 0; n < len; n++) begin
            if ($urandom_range(0, 9) == 0)
                send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_request(8'($urandom_range(0, 255)), 1'b1, fused && n == len - 1);
        end
        if (!fused || len == 0)
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // stop offering and wait for every queued digest word
    task automatic drain_digests();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        while (digest_model.pending_words.size() != 0)
            @(posedge i_clk);
    endtask

    // digest side: check accepted words, randomize ready
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_tvalid && m_tready)
                digest_model.check_digest_word(m_tdata, m_tuser, m_tlast);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = 300;
                m_tready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                m_tready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // stimulus
    initial begin
        int unsigned len;
        digest_model = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty message, then a request with neither byte nor end
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'h5a, 1'b0, 1'b0);
        // "abc" with the end riding on the last byte
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);
        // extreme bytes, end on its own
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'hff, 1'b1, 1'b0);
        send_request(8'h3c, 1'b0, 1'b1);
        // single byte and end together
        send_request(8'hff, 1'b1, 1'b1);
        send_request(8'ha5, 1'b0, 1'b0);
        send_request(8'hff, 1'b0, 1'b1);

        // padding boundaries first, then mostly short messages
        for (int unsigned msg_no = 0; request_count < 400; msg_no++) begin
            no_idle = (msg_no % 6 == 5);
            if (msg_no == 5)
                hold_off_req = 1'b1;
            if (msg_no == 9)
                drain_digests();
            if (msg_no < 4)
                len = boundary_len[msg_no];
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(55, 65);
            else
                len = $urandom_range(0, 12);
            send_message(len);
        end

        drain_digests();
        repeat (200) @(posedge i_clk);
        if (digest_model.mismatch_count == 0 && digest_model.pending_words.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
